>>> rtl/hwc_pkg.sv
`timescale 1ns / 1ps

package hwc_pkg;

  localparam int COORD_BITS_DEF = 32;

  // inverse hex basis, Q0.28
  localparam logic [27:0] K_SQRT3_3    = 28'd154981283;
  localparam logic [27:0] K_THIRD      = 28'd89478485;
  localparam logic [27:0] K_TWO_THIRDS = 28'd178956971;

  localparam logic [31:0] INV_RADIUS_RST = 32'd42949673;

  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_INV_RADIUS = 2'd2
  } reg_idx_t;

  // distance of a Q.16 value from its rounded cell, taken from the low 16 bits
  function automatic logic [15:0] rnd_err(input logic [15:0] lo);
    logic [15:0] mag;
    mag = lo[15] ? (~lo + 16'd1) : lo;
    return mag;
  endfunction

endpackage

>>> rtl/hwc_if.sv
`timescale 1ns / 1ps

interface hwc_in_if #(
  parameter int COORD_BITS = hwc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] world_x;
  logic signed [COORD_BITS-1:0] world_y;

  modport source (output valid, output world_x, output world_y, input ready);
  modport sink   (input valid, input world_x, input world_y, output ready);
endinterface

interface hwc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_q;
  logic signed [15:0] cell_r;
  logic               clipped;

  modport source (output valid, output cell_q, output cell_r, output clipped, input ready);
  modport sink   (input valid, input cell_q, input cell_r, input clipped, output ready);
endinterface

>>> rtl/hex_world_to_cube_round.sv
`timescale 1ns / 1ps

// World point to pointy-top hex cell, axial (q, r).
// in_ch takes one word per point (world_x, world_y, signed Q.8); out_ch gives
// one word per point (cell_q, cell_r, clipped) in the same order.
// The APB port holds origin_x (0x0), origin_y (0x4) and inv_radius (0x8);
// with COORD_BITS above 32 the data is 64 bits and the stride 8 bytes.
// Write the registers only while no point is in flight.
// Throughput: one point per cycle while out_ch.ready is high; the nine
// pipeline stages each carry a valid bit and take a new word whenever
// the stage ahead of them frees up.
// When out_ch.ready is low the output stage holds its word and the stages
// behind it keep filling until each holds a word; then in_ch.ready drops.
// Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads origin 0,0
// and inv_radius 42949673 (radius 100).

module hex_world_to_cube_round #(
  parameter  int COORD_BITS = hwc_pkg::COORD_BITS_DEF,
  localparam int CFG_DW     = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_LSB   = (COORD_BITS > 32) ? 3 : 2,
  localparam int ADDR_W     = ADDR_LSB + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  hwc_in_if.sink            in_ch,
  hwc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);
  import hwc_pkg::*;

  localparam int NS = 9;
  localparam int DW = COORD_BITS + 1;
  localparam int L1 = DW / 2;
  localparam int PW = DW + 29;
  localparam int QW = COORD_BITS + 10;
  localparam int L2 = QW / 2;
  localparam int FW = QW + 33;
  localparam int RW = QW - 14;
  localparam int SW = (RW + 1 > 17) ? RW + 1 : 17;
  localparam int PLW = L1 + 28;
  localparam int PHW = DW - L1 + 29;
  localparam int MLW = L2 + 32;
  localparam int MHW = QW - L2 + 33;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

  typedef enum logic [1:0] {
    FIX_NONE = 2'd0,
    FIX_Q    = 2'd1,
    FIX_R    = 2'd2
  } fix_t;

  // configuration
  logic signed [COORD_BITS-1:0] origin_x_r;
  logic signed [COORD_BITS-1:0] origin_y_r;
  logic [31:0]                  inv_radius_r;
  reg_idx_t                     reg_idx;
  logic                         cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      inv_radius_r <= INV_RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X:   origin_x_r   <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y:   origin_y_r   <= pwdata[COORD_BITS-1:0];
        REG_INV_RADIUS: inv_radius_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:   prdata = CFG_DW'(origin_x_r);
      REG_ORIGIN_Y:   prdata = CFG_DW'(origin_y_r);
      REG_INV_RADIUS: prdata = CFG_DW'(inv_radius_r);
      default:        prdata = '0;
    endcase
  end

  // pipeline flow control
  logic [NS:1] v_r;
  logic [NS:1] v_src;
  logic [NS:1] adv;

  assign v_src = {v_r[NS-1:1], in_ch.valid};

  always_comb begin
    adv[NS] = ~v_r[NS] | out_ch.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = ~v_r[k] | adv[k+1];
    end
  end

  assign in_ch.ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_src[k];
        end
      end
    end
  end

  // s1: offset from origin
  logic signed [DW-1:0] dx_r, dy_r, ndy_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dx_r  <= DW'(in_ch.world_x) - DW'(origin_x_r);
      dy_r  <= DW'(in_ch.world_y) - DW'(origin_y_r);
      ndy_r <= DW'(origin_y_r) - DW'(in_ch.world_y);
    end
  end

  // s2: basis partial products
  logic [L1+27:0]           pa_lo_r, pb_lo_r, pc_lo_r;
  logic signed [DW-L1+28:0] pa_hi_r, pb_hi_r, pc_hi_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pa_lo_r <= PLW'(dx_r[L1-1:0]) * PLW'(K_SQRT3_3);
      pb_lo_r <= PLW'(ndy_r[L1-1:0]) * PLW'(K_THIRD);
      pc_lo_r <= PLW'(dy_r[L1-1:0]) * PLW'(K_TWO_THIRDS);
      pa_hi_r <= PHW'($signed(dx_r[DW-1:L1])) * PHW'($signed({1'b0, K_SQRT3_3}));
      pb_hi_r <= PHW'($signed(ndy_r[DW-1:L1])) * PHW'($signed({1'b0, K_THIRD}));
      pc_hi_r <= PHW'($signed(dy_r[DW-1:L1])) * PHW'($signed({1'b0, K_TWO_THIRDS}));
    end
  end

  // s3: combine, floor to Q.16
  logic signed [PW-1:0] pa_sum, pb_sum, pc_sum;
  logic signed [QW-1:0] ta_r, tb_r, rp3_r;

  always_comb begin
    pa_sum = (PW'(pa_hi_r) <<< L1) + PW'($signed({1'b0, pa_lo_r}));
    pb_sum = (PW'(pb_hi_r) <<< L1) + PW'($signed({1'b0, pb_lo_r}));
    pc_sum = (PW'(pc_hi_r) <<< L1) + PW'($signed({1'b0, pc_lo_r}));
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ta_r  <= pa_sum[QW+19:20];
      tb_r  <= pb_sum[QW+19:20];
      rp3_r <= pc_sum[QW+19:20];
    end
  end

  // s4: q'
  logic signed [QW-1:0] qp_r, rp4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      qp_r  <= ta_r + tb_r;
      rp4_r <= rp3_r;
    end
  end

  // s5: radius partial products
  logic [L2+31:0]           mq_lo_r, mr_lo_r;
  logic signed [QW-L2+32:0] mq_hi_r, mr_hi_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      mq_lo_r <= MLW'(qp_r[L2-1:0]) * MLW'(inv_radius_r);
      mr_lo_r <= MLW'(rp4_r[L2-1:0]) * MLW'(inv_radius_r);
      mq_hi_r <= MHW'($signed(qp_r[QW-1:L2])) * MHW'($signed({1'b0, inv_radius_r}));
      mr_hi_r <= MHW'($signed(rp4_r[QW-1:L2])) * MHW'($signed({1'b0, inv_radius_r}));
    end
  end

  // s6: fractional cube coordinates
  logic signed [FW-1:0] mq_sum, mr_sum;
  logic signed [QW-1:0] fq_r, fr_r;

  always_comb begin
    mq_sum = (FW'(mq_hi_r) <<< L2) + FW'($signed({1'b0, mq_lo_r}));
    mr_sum = (FW'(mr_hi_r) <<< L2) + FW'($signed({1'b0, mr_lo_r}));
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      fq_r <= mq_sum[QW+31:32];
      fr_r <= mr_sum[QW+31:32];
    end
  end

  // s7: s component, round q and r
  logic signed [QW:0]   fs_r;
  logic signed [RW-1:0] rq7_r, rr7_r;
  logic [15:0]          eq_r, er_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      fs_r  <= -(QW+1)'(fq_r) - (QW+1)'(fr_r);
      rq7_r <= RW'($signed(fq_r[QW-1:16])) + RW'(fq_r[15]);
      rr7_r <= RW'($signed(fr_r[QW-1:16])) + RW'(fr_r[15]);
      eq_r  <= rnd_err(fq_r[15:0]);
      er_r  <= rnd_err(fr_r[15:0]);
    end
  end

  // s8: round s, pick the component to rebuild
  logic [15:0]          es;
  fix_t                 fix;
  logic signed [RW-1:0] rq8_r, rr8_r, rs8_r;
  fix_t                 fix_r;

  always_comb begin
    es = rnd_err(fs_r[15:0]);
    if (eq_r > er_r && eq_r > es) begin
      fix = FIX_Q;
    end else if (er_r > es) begin
      fix = FIX_R;
    end else begin
      fix = FIX_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      rq8_r <= rq7_r;
      rr8_r <= rr7_r;
      rs8_r <= RW'($signed(fs_r[QW:16])) + RW'(fs_r[15]);
      fix_r <= fix;
    end
  end

  // s9: rebuild, saturate, output register
  logic signed [SW-1:0] q_w, r_w;
  logic signed [15:0]   q_sat, r_sat;
  logic                 clip;
  logic signed [15:0]   cell_q_r, cell_r_r;
  logic                 clipped_r;

  always_comb begin
    q_w = SW'(rq8_r);
    r_w = SW'(rr8_r);
    case (fix_r)
      FIX_Q:   q_w = -SW'(rr8_r) - SW'(rs8_r);
      FIX_R:   r_w = -SW'(rq8_r) - SW'(rs8_r);
      default: ;
    endcase
    clip = 1'b0;
    if (q_w > SAT_HI) begin
      q_sat = 16'sd32767;
      clip  = 1'b1;
    end else if (q_w < SAT_LO) begin
      q_sat = -16'sd32768;
      clip  = 1'b1;
    end else begin
      q_sat = q_w[15:0];
    end
    if (r_w > SAT_HI) begin
      r_sat = 16'sd32767;
      clip  = 1'b1;
    end else if (r_w < SAT_LO) begin
      r_sat = -16'sd32768;
      clip  = 1'b1;
    end else begin
      r_sat = r_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      cell_q_r  <= q_sat;
      cell_r_r  <= r_sat;
      clipped_r <= clip;
    end
  end

  assign out_ch.valid   = v_r[NS];
  assign out_ch.cell_q  = cell_q_r;
  assign out_ch.cell_r  = cell_r_r;
  assign out_ch.clipped = clipped_r;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 131;

  typedef struct packed {
    logic signed [15:0] q;
    logic signed [15:0] r;
    logic               clip;
  } cell_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    reg_id;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    cell_t       want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hwc_in_if  in_ch ();
  hwc_out_if out_ch ();

  hex_world_to_cube_round uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [31:0] grid_org_x;
  logic signed [31:0] grid_org_y;
  logic [31:0]        grid_inv_radius;

  cell_t     pending_cells[$];
  stim_row_t stim_rows[$];
  int        mismatches  = 0;
  int        send_pct    = 0;
  int        stall_pct   = 0;
  int        hold_cycles = 0;
  int        hold_req    = 0;
  int        idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic cell_t hex_cell_of(input logic signed [31:0] wx,
                                        input logic signed [31:0] wy);
    logic signed [127:0] dx, dy, kq, kt, k2, ir;
    logic signed [127:0] qp, rp, fq, fr, fs, rq, rr, rs, eq, er, es;
    cell_t c;
    kq = 128'(K_SQRT3_3);
    kt = 128'(K_THIRD);
    k2 = 128'(K_TWO_THIRDS);
    ir = 128'(grid_inv_radius);
    dx = 128'(wx) - 128'(grid_org_x);
    dy = 128'(wy) - 128'(grid_org_y);
    qp = ((dx * kq) >>> 20) + (((-dy) * kt) >>> 20);
    rp = (dy * k2) >>> 20;
    fq = (qp * ir) >>> 32;
    fr = (rp * ir) >>> 32;
    fs = -fq - fr;
    rq = (fq + 32768) >>> 16;
    rr = (fr + 32768) >>> 16;
    rs = (fs + 32768) >>> 16;
    eq = fq - rq * 65536;
    er = fr - rr * 65536;
    es = fs - rs * 65536;
    if (eq < 0) eq = -eq;
    if (er < 0) er = -er;
    if (es < 0) es = -es;
    if (eq > er && eq > es) rq = -rr - rs;
    else if (er > es) rr = -rq - rs;
    c.clip = 1'b0;
    if (rq > 32767) begin
      c.q = 16'sh7fff;
      c.clip = 1'b1;
    end else if (rq < -32768) begin
      c.q = -16'sh8000;
      c.clip = 1'b1;
    end else begin
      c.q = rq[15:0];
    end
    if (rr > 32767) begin
      c.r = 16'sh7fff;
      c.clip = 1'b1;
    end else if (rr < -32768) begin
      c.r = -16'sh8000;
      c.clip = 1'b1;
    end else begin
      c.r = rr[15:0];
    end
    return c;
  endfunction

  task automatic write_reg(input reg_idx_t id, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {id, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (id)
      REG_ORIGIN_X:   grid_org_x = val;
      REG_ORIGIN_Y:   grid_org_y = val;
      REG_INV_RADIUS: grid_inv_radius = val;
      default: ;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val)
      report_mismatch($sformatf("readback reg %s: got %h want %h", id.name(), prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(input logic [31:0] wx, input logic [31:0] wy,
                            input bit typed, input cell_t want);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.world_x <= wx;
    in_ch.world_y <= wy;
    do @(posedge clk); while (!in_ch.ready);
    pending_cells.push_back(typed ? want : hex_cell_of(wx, wy));
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cells.size() != 0);
  endtask

  task automatic add_point(input logic [31:0] wx, input logic [31:0] wy);
    stim_row_t row;
    row = '{is_cfg: 1'b0, reg_id: REG_ORIGIN_X, a: wx, b: wy, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [31:0] wx, input logic [31:0] wy,
                           input int q, input int r, input bit clip);
    stim_row_t row;
    row = '{is_cfg: 1'b0, reg_id: REG_ORIGIN_X, a: wx, b: wy, typed: 1'b1,
            want: '{q: 16'(q), r: 16'(r), clip: clip}};
    stim_rows.push_back(row);
  endtask

  task automatic add_cfg(input reg_idx_t id, input logic [31:0] val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, reg_id: id, a: val, b: '0, typed: 1'b0, want: '0};
    stim_rows.push_back(row);
  endtask

  // receiver: random stalls plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_cycles;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    cell_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected word q=%0d r=%0d clip=%0d",
                                  out_ch.cell_q, out_ch.cell_r, out_ch.clipped));
      end else begin
        want = pending_cells.pop_front();
        if (out_ch.cell_q !== want.q)
          report_mismatch($sformatf("cell_q got %0d want %0d", out_ch.cell_q, want.q));
        if (out_ch.cell_r !== want.r)
          report_mismatch($sformatf("cell_r got %0d want %0d", out_ch.cell_r, want.r));
        if (out_ch.clipped !== want.clip)
          report_mismatch($sformatf("clipped got %0d want %0d", out_ch.clipped, want.clip));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] ox, oy, ir, wx, wy;
    int          radius;
    int          span;
    cell_t       none;
    none = '0;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.world_x <= '0;
    in_ch.world_y <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    grid_org_x      = '0;
    grid_org_y      = '0;
    grid_inv_radius = INV_RADIUS_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_typed(32'h0, 32'h0, 0, 0, 1'b0);
    add_typed(32'h7fffffff, 32'h0, 32767, 0, 1'b1);
    add_typed(32'h80000000, 32'h0, -32768, 0, 1'b1);
    add_point(32'h0, 32'h7fffffff);
    add_point(32'h0, 32'h80000000);
    add_point(32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h80000000);
    add_point(32'h7fffffff, 32'h80000000);
    add_point(32'h80000000, 32'h7fffffff);
    add_point(32'd25600, 32'd0);
    add_point(32'd0, 32'd38400);
    add_point(32'hffffffff, 32'hffffffff);
    add_point(32'd1, 32'd1);
    // zero reciprocal radius
    add_cfg(REG_INV_RADIUS, 32'h0);
    add_typed(32'h7fffffff, 32'h80000000, 0, 0, 1'b0);
    add_typed(32'h12345678, 32'hdeadbeef, 0, 0, 1'b0);
    add_cfg(REG_INV_RADIUS, 32'hffffffff);
    add_typed(32'h0, 32'h0, 0, 0, 1'b0);
    add_point(32'd300, 32'd200);
    add_point(32'h7fffffff, 32'h0);
    add_cfg(REG_INV_RADIUS, 32'h1);
    add_point(32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h7fffffff);
    add_cfg(REG_ORIGIN_X, 32'h80000000);
    add_cfg(REG_ORIGIN_Y, 32'h7fffffff);
    add_cfg(REG_INV_RADIUS, INV_RADIUS_RST);
    add_point(32'h7fffffff, 32'h80000000);
    add_typed(32'h80000000, 32'h7fffffff, 0, 0, 1'b0);
    add_cfg(REG_ORIGIN_X, 32'h7fffffff);
    add_cfg(REG_ORIGIN_Y, 32'h80000000);
    add_point(32'h80000000, 32'h7fffffff);
    add_point(32'h7fffffff, 32'h80000100);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain_pipe();
        write_reg(stim_rows[i].reg_id, stim_rows[i].a);
      end else begin
        send_point(stim_rows[i].a, stim_rows[i].b, stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_pipe();
      radius = $urandom_range(1, 1000);
      ox = ($urandom_range(0, 2) == 0) ? $urandom
                                         : 32'($urandom_range(0, 2097152)) - 32'd1048576;
      oy = ($urandom_range(0, 2) == 0) ? $urandom
                                         : 32'($urandom_range(0, 2097152)) - 32'd1048576;
      ir = (radius == 1) ? 32'hffffffff : 32'(64'h1_0000_0000 / radius);
      if ($urandom_range(0, 3) == 0) ir = $urandom;
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_INV_RADIUS, ir);
      case (p % 4)
        0: begin
          send_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          send_pct  = 47;
          stall_pct = 0;
        end
        2: begin
          send_pct  = 0;
          stall_pct = 47;
        end
        default: begin
          send_pct  = 10;
          stall_pct = 10;
        end
      endcase
      span = radius * 2048;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 40) begin
          hold_cycles = 150;
          hold_req++;
        end
        if (p == 5 && i == 65) drain_pipe();
        case ($urandom_range(0, 9))
          0, 1: begin
            wx = $urandom;
            wy = $urandom;
          end
          2: begin
            wx = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            wy = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
          end
          3, 4: begin
            wx = grid_org_x + ($signed($urandom) >>> $urandom_range(0, 8));
            wy = grid_org_y + ($signed($urandom) >>> $urandom_range(0, 8));
          end
          default: begin
            wx = grid_org_x + 32'($urandom_range(0, 2 * span)) - 32'(span);
            wy = grid_org_y + 32'($urandom_range(0, 2 * span)) - 32'(span);
          end
        endcase
        send_point(wx, wy, 1'b0, none);
      end
    end

    drain_pipe();
    repeat (20) @(posedge clk);
    if (pending_cells.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_cells.size()));
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
